// ===== sv/ioapic_pkg.sv =====
// ioapic_pkg: payload structs, function codes and entry constants for the
// IOAPIC redirection controller. No dependencies.
package ioapic_pkg;

	typedef enum logic [2:0] {
		FN_RD     = 3'd0,
		FN_WR     = 3'd1,
		FN_ASSERT = 3'd2,
		FN_DEASRT = 3'd3,
		FN_PULSE  = 3'd4,
		FN_EOI    = 3'd5
	} func_t;

	localparam logic [7:0] OFF_INDEX  = 8'h00;
	localparam logic [7:0] OFF_WINDOW = 8'h10;
	localparam logic [7:0] OFF_EOI    = 8'h40;
	localparam logic [7:0] VERSION_ID = 8'h11;
	localparam logic [63:0] RESET_ENTRY = 64'h0001000000010000;
	localparam logic [31:0] RO_LOW = 32'h0000_5000;
	localparam int B_POL   = 13;
	localparam int B_RIRR  = 14;
	localparam int B_LEVEL = 15;
	localparam int B_MASK  = 16;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  offset;
		logic [31:0] wdata;
		logic [5:0]  pin_number;
		logic [7:0]  eoi_vector;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] read_data;
		logic [7:0]  int_vector;
		logic [7:0]  destination;
		logic        dest_physical;
		logic [2:0]  delivery_mode;
		logic        level_trigger;
		logic        error;
		logic        tmr_update;
		logic        remap_request;
		logic        last;
	} out_t;

	function automatic out_t msg_of(input logic [63:0] e);
		out_t r;
		r = '0;
		r.kind = 1'b1;
		r.int_vector = e[7:0];
		r.destination = e[63:56];
		r.dest_physical = ~e[11];
		r.delivery_mode = e[10:8];
		r.level_trigger = e[15];
		return r;
	endfunction

endpackage

// ===== sv/ioapic_front.sv =====
// ioapic_front: two-entry command queue.
// Depends on ioapic_pkg.
module ioapic_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  ioapic_pkg::in_t  data,
	output logic             q_valid,
	input  logic             q_pop,
	output ioapic_pkg::in_t  q_data
);
	ioapic_pkg::in_t mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	assign stall = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (valid && !stall) mem_q[wr_q] <= data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (valid && !stall) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(valid && !stall) - 2'(q_pop);
		end
	end
endmodule

// ===== sv/ioapic_back.sv =====
// ioapic_back: register file and sequencer that executes one command, scanning
// pins one per cycle for EOI while the output is not stalled. Depends on ioapic_pkg.
module ioapic_back #(
	parameter int PINS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  ioapic_pkg::in_t  cmd,
	output logic             valid,
	input  logic             stall,
	output ioapic_pkg::out_t data
);
	localparam int PW = (PINS > 1) ? $clog2(PINS) : 1;

	typedef enum logic [2:0] {IDLE, PSTEP, EOI, DONE} st_t;

	st_t st_q;
	ioapic_pkg::in_t c_q;
	logic [63:0] tbl_q [PINS];
	logic [7:0]  cnt_q [PINS];
	logic [31:0] index_q, id_q;
	logic [PW-1:0] p_q;
	logic [31:0] evec_q;
	logic down_q, err_q, tmr_q, remap_q;
	logic [31:0] rd_q;
	ioapic_pkg::out_t o_q;
	logic ov_q;

	logic out_free;
	assign out_free = !ov_q || !stall;
	assign valid = ov_q;
	assign data = o_q;
	assign cmd_pop = (st_q == IDLE) && cmd_valid;

	// window decode
	logic [7:0] reg_idx;
	logic [7:0] k;
	logic win_ent;
	logic [PW-1:0] wp;
	logic [31:0] win_rd;
	always_comb begin
		reg_idx = cmd.offset == ioapic_pkg::OFF_WINDOW ? index_q[7:0] : index_q[7:0];
		k = reg_idx - 8'h10;
		win_ent = reg_idx >= 8'h10 && {1'b0, k} < 9'(2 * PINS);
		wp = PW'(k[7:1]);
		win_rd = 32'd0;
		if (reg_idx == 8'd0 || reg_idx == 8'd2) win_rd = id_q;
		else if (reg_idx == 8'd1)
			win_rd = {8'd0, 8'(PINS - 1), 8'd0, ioapic_pkg::VERSION_ID};
		else if (win_ent) win_rd = k[0] ? tbl_q[wp][63:32] : tbl_q[wp][31:0];
	end

	// entry write
	logic [63:0] oldv, newv, ch;
	always_comb begin
		oldv = tbl_q[wp];
		if (k[0]) newv = {cmd.wdata, oldv[31:0]};
		else newv = {oldv[63:32],
			(oldv[31:0] & ioapic_pkg::RO_LOW) | (cmd.wdata & ~ioapic_pkg::RO_LOW)};
		ch = oldv ^ newv;
	end

	// count step on current pin
	logic signed [7:0] oc, nc;
	always_comb begin
		oc = $signed(cnt_q[c_q.pin_number[PW-1:0]]);
		nc = oc;
		if (!down_q) begin
			if (oc < 8'sd127) nc = oc + 8'sd1;
		end else if (oc > -8'sd127) nc = oc - 8'sd1;
	end

	logic [63:0] se;
	logic signed [7:0] sc;
	logic [PW-1:0] cp;
	assign cp = c_q.pin_number[PW-1:0];
	assign se = tbl_q[p_q];
	assign sc = $signed(cnt_q[p_q]);

	ioapic_pkg::out_t comp;
	always_comb begin
		comp = '0;
		comp.read_data = rd_q;
		comp.error = err_q;
		comp.tmr_update = tmr_q;
		comp.remap_request = remap_q;
		comp.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			ov_q <= 1'b0;
			index_q <= '0;
			id_q <= '0;
			for (int i = 0; i < PINS; i++) begin
				tbl_q[i] <= ioapic_pkg::RESET_ENTRY;
				cnt_q[i] <= '0;
			end
		end else begin
			if (ov_q && !stall) ov_q <= 1'b0;
			case (st_q)
				IDLE: if (cmd_valid) begin
					c_q <= cmd;
					rd_q <= '0;
					err_q <= 1'b0;
					tmr_q <= 1'b0;
					remap_q <= 1'b0;
					down_q <= cmd.func == ioapic_pkg::FN_DEASRT;
					p_q <= '0;
					st_q <= DONE;
					case (cmd.func)
						ioapic_pkg::FN_RD: begin
							if (cmd.offset == ioapic_pkg::OFF_INDEX) rd_q <= index_q;
							else if (cmd.offset == ioapic_pkg::OFF_WINDOW) rd_q <= win_rd;
						end
						ioapic_pkg::FN_WR: begin
							if (cmd.offset == ioapic_pkg::OFF_INDEX) index_q <= cmd.wdata;
							else if (cmd.offset == ioapic_pkg::OFF_EOI) begin
								evec_q <= cmd.wdata;
								st_q <= EOI;
							end else if (cmd.offset == ioapic_pkg::OFF_WINDOW) begin
								if (reg_idx == 8'd0) id_q <= {cmd.wdata[31:24], 24'd0};
								else if (win_ent) begin
									tbl_q[wp] <= newv;
									tmr_q <= |(ch & ~(64'(1) << ioapic_pkg::B_MASK)
										& ~(64'(1) << ioapic_pkg::B_POL));
									remap_q <= ch[ioapic_pkg::B_MASK] | ch[ioapic_pkg::B_LEVEL]
										| ch[ioapic_pkg::B_POL];
									// send after write: go to PSTEP when unmasked, remote IRR clear and count above zero
									if (!newv[ioapic_pkg::B_MASK] && !newv[ioapic_pkg::B_RIRR]
										&& $signed(cnt_q[wp]) > 8'sd0) begin
										p_q <= wp;
										st_q <= PSTEP;
									end
								end
							end
						end
						ioapic_pkg::FN_ASSERT, ioapic_pkg::FN_DEASRT, ioapic_pkg::FN_PULSE: begin
							if ({26'd0, cmd.pin_number} >= 32'(PINS)) err_q <= 1'b1;
							else st_q <= PSTEP;
						end
						ioapic_pkg::FN_EOI: begin
							evec_q <= {24'd0, cmd.eoi_vector};
							st_q <= EOI;
						end
						default: ;
					endcase
				end
				PSTEP: if (out_free) begin
					if (c_q.func == ioapic_pkg::FN_WR) begin
						// message for an entry write (unmasked already checked)
						if (se[ioapic_pkg::B_LEVEL]) tbl_q[p_q][ioapic_pkg::B_RIRR] <= 1'b1;
						o_q <= ioapic_pkg::msg_of(se);
						ov_q <= 1'b1;
						st_q <= DONE;
					end else begin
						cnt_q[cp] <= nc;
						if (nc < 0) err_q <= 1'b1;
						if (oc == 8'sd0 && nc == 8'sd1 && !tbl_q[cp][ioapic_pkg::B_MASK]) begin
							if (tbl_q[cp][ioapic_pkg::B_LEVEL])
								tbl_q[cp][ioapic_pkg::B_RIRR] <= 1'b1;
							o_q <= ioapic_pkg::msg_of(tbl_q[cp]);
							ov_q <= 1'b1;
						end
						if (c_q.func == ioapic_pkg::FN_PULSE && !down_q) down_q <= 1'b1;
						else st_q <= DONE;
					end
				end
				EOI: if (out_free) begin
					if (se[ioapic_pkg::B_RIRR] && {24'd0, se[7:0]} == evec_q) begin
						if (sc > 8'sd0 && !se[ioapic_pkg::B_MASK]) begin
							tbl_q[p_q][ioapic_pkg::B_RIRR] <= se[ioapic_pkg::B_LEVEL];
							o_q <= ioapic_pkg::msg_of(se);
							ov_q <= 1'b1;
						end else tbl_q[p_q][ioapic_pkg::B_RIRR] <= 1'b0;
					end
					if (32'(p_q) == 32'(PINS - 1)) st_q <= DONE;
					else p_q <= p_q + PW'(1);
				end
				DONE: if (out_free) begin
					o_q <= comp;
					ov_q <= 1'b1;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== sv/ioapic_redirection_controller.sv =====
// ioapic_redirection_controller: top level of the IOAPIC register block.
// Depends on ioapic_pkg, ioapic_front, ioapic_back.
//
// Usage: the request channel (req_valid/req_stall/req) carries MMIO
// accesses, pin events and EOI broadcasts. The response channel
// (rsp_valid/rsp_stall/rsp) returns zero or more interrupt messages in pin
// order, then one completion with last set.
// Flow: a command waits in a two-entry queue, then the back sequencer runs
// it; an entry write may send a message, a pulse steps the count up and then
// down, and an EOI (broadcast or register write) scans the pins in order, one
// pin per cycle of the scan loop while the response is not stalled.
// Throughput is one command at a time through the sequencer; the queue keeps
// accepting while results wait.
// Reset: index and ID clear, every entry reads masked, all counts zero.
// A stalled response holds its data; the sequencer waits and the queue
// stalls the request side once both entries are full.
module ioapic_redirection_controller #(
	parameter int PINS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ioapic_pkg::in_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ioapic_pkg::out_t rsp
);
	logic q_valid, q_pop;
	ioapic_pkg::in_t q_data;

	ioapic_front u_front (
		.clk(clk), .arst_n(arst_n),
		.valid(req_valid), .stall(req_stall), .data(req),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	ioapic_back #(.PINS(PINS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_pop(q_pop), .cmd(q_data),
		.valid(rsp_valid), .stall(rsp_stall), .data(rsp)
	);
endmodule

// ===== bench/ioapic_redirection_controller_tb.sv =====
// Testbench for ioapic_redirection_controller: drives MMIO accesses, pin events
// and EOI broadcasts, predicts interrupt messages and completions, checks them.
// Depends on ioapic_pkg and the controller RTL.
`timescale 1ns / 100ps

module ioapic_redirection_controller_tb;

	localparam int PINS = 24;
	localparam int N_RAND = 60;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ioapic_pkg::in_t  req;
	logic rsp_valid;
	logic rsp_stall;
	ioapic_pkg::out_t rsp;

	ioapic_redirection_controller #(.PINS(PINS)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// shadow state of the register block
	logic [31:0] sh_index;
	logic [31:0] sh_id;
	logic [63:0] sh_entry [PINS];
	int          sh_count [PINS];

	ioapic_pkg::out_t pending_rsp [$];
	int   n_fail;
	int   hold_cycles;
	bit   rx_random;

	function automatic ioapic_pkg::out_t message_of(input logic [63:0] e);
		ioapic_pkg::out_t r;
		r = '0;
		r.kind = 1'b1;
		r.int_vector = e[7:0];
		r.destination = e[63:56];
		r.dest_physical = ~e[11];
		r.delivery_mode = e[10:8];
		r.level_trigger = e[15];
		return r;
	endfunction

	function automatic void deliver(input int p);
		if (sh_entry[p][ioapic_pkg::B_MASK])
			return;
		if (sh_entry[p][ioapic_pkg::B_LEVEL])
			sh_entry[p][ioapic_pkg::B_RIRR] = 1'b1;
		pending_rsp.push_back(message_of(sh_entry[p]));
	endfunction

	function automatic bit count_step(input int p, input bit up);
		int oldc;
		oldc = sh_count[p];
		if (up && sh_count[p] < 127)
			sh_count[p]++;
		else if (!up && sh_count[p] > -127)
			sh_count[p]--;
		if (oldc == 0 && sh_count[p] == 1)
			deliver(p);
		return sh_count[p] < 0;
	endfunction

	task automatic eoi_scan(input logic [31:0] vec);
		for (int p = 0; p < PINS; p++) begin
			if (sh_entry[p][ioapic_pkg::B_RIRR] && {24'd0, sh_entry[p][7:0]} == vec) begin
				sh_entry[p][ioapic_pkg::B_RIRR] = 1'b0;
				if (sh_count[p] > 0)
					deliver(p);
			end
		end
	endtask

	function automatic logic [31:0] window_value();
		logic [7:0] r;
		logic [7:0] k;
		r = sh_index[7:0];
		if (r == 8'd0 || r == 8'd2)
			return sh_id;
		if (r == 8'd1)
			return 32'(((PINS - 1) << 16) | ioapic_pkg::VERSION_ID);
		if (r >= 8'h10 && r < 8'h10 + 2 * PINS) begin
			k = r - 8'h10;
			return k[0] ? sh_entry[k >> 1][63:32] : sh_entry[k >> 1][31:0];
		end
		return '0;
	endfunction

	task automatic predict_transfer(input ioapic_pkg::in_t it);
		ioapic_pkg::out_t done;
		logic [7:0] r;
		logic [7:0] k;
		logic [63:0] oldv;
		logic [63:0] newv;
		logic [63:0] ch;
		int p;
		bit e1;
		bit e2;
		done = '0;
		done.last = 1'b1;
		case (it.func)
		ioapic_pkg::FN_RD: begin
			if (it.offset == ioapic_pkg::OFF_INDEX)
				done.read_data = sh_index;
			else if (it.offset == ioapic_pkg::OFF_WINDOW)
				done.read_data = window_value();
		end
		ioapic_pkg::FN_WR: begin
			if (it.offset == ioapic_pkg::OFF_INDEX) begin
				sh_index = it.wdata;
			end else if (it.offset == ioapic_pkg::OFF_EOI) begin
				eoi_scan(it.wdata);
			end else if (it.offset == ioapic_pkg::OFF_WINDOW) begin
				r = sh_index[7:0];
				if (r == 8'd0) begin
					sh_id = it.wdata & 32'hff000000;
				end else if (r >= 8'h10 && r < 8'h10 + 2 * PINS) begin
					k = r - 8'h10;
					p = k >> 1;
					oldv = sh_entry[p];
					newv = oldv;
					if (k[0])
						newv[63:32] = it.wdata;
					else
						newv[31:0] = (oldv[31:0] & ioapic_pkg::RO_LOW)
							| (it.wdata & ~ioapic_pkg::RO_LOW);
					ch = oldv ^ newv;
					sh_entry[p] = newv;
					if ((ch & ~((64'd1 << ioapic_pkg::B_MASK) | (64'd1 << ioapic_pkg::B_POL)))
						!= 0)
						done.tmr_update = 1'b1;
					if (!newv[ioapic_pkg::B_MASK] && !newv[ioapic_pkg::B_RIRR]
						&& sh_count[p] > 0)
						deliver(p);
					if (ch[ioapic_pkg::B_MASK] || ch[ioapic_pkg::B_LEVEL]
						|| ch[ioapic_pkg::B_POL])
						done.remap_request = 1'b1;
				end
			end
		end
		ioapic_pkg::FN_ASSERT, ioapic_pkg::FN_DEASRT, ioapic_pkg::FN_PULSE: begin
			p = it.pin_number;
			if (p >= PINS) begin
				done.error = 1'b1;
			end else if (it.func == ioapic_pkg::FN_ASSERT) begin
				done.error = count_step(p, 1'b1);
			end else if (it.func == ioapic_pkg::FN_DEASRT) begin
				done.error = count_step(p, 1'b0);
			end else begin
				e1 = count_step(p, 1'b1);
				e2 = count_step(p, 1'b0);
				done.error = e1 | e2;
			end
		end
		ioapic_pkg::FN_EOI: eoi_scan({24'd0, it.eoi_vector});
		default: ;
		endcase
		pending_rsp.push_back(done);
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(8, 30);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// send one transfer; prediction happens at acceptance
	task automatic send_item(input ioapic_pkg::in_t it, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_transfer(it);
	endtask

	function automatic ioapic_pkg::in_t make_item(input int f, input int off,
		input logic [31:0] wd, input int pin, input int vec);
		ioapic_pkg::in_t it;
		it.func = 3'(f);
		it.offset = 8'(off);
		it.wdata = wd;
		it.pin_number = 6'(pin);
		it.eoi_vector = 8'(vec);
		return it;
	endfunction

	task automatic mmio_write(input int off, input logic [31:0] wd);
		send_item(make_item(ioapic_pkg::FN_WR, off, wd, $urandom, $urandom), 1'b1);
	endtask

	task automatic mmio_read(input int off);
		send_item(make_item(ioapic_pkg::FN_RD, off, $urandom, $urandom, $urandom), 1'b1);
	endtask

	task automatic pin_event(input int f, input int pin);
		send_item(make_item(f, $urandom, $urandom, pin, $urandom), 1'b1);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_id_version();
		mmio_write(ioapic_pkg::OFF_INDEX, 32'd0);
		mmio_write(ioapic_pkg::OFF_WINDOW, 32'hffffffff);
		mmio_read(ioapic_pkg::OFF_WINDOW);
		mmio_write(ioapic_pkg::OFF_INDEX, 32'hffffff01);
		mmio_read(ioapic_pkg::OFF_WINDOW);
		mmio_read(ioapic_pkg::OFF_INDEX);
		mmio_write(ioapic_pkg::OFF_INDEX, 32'd2);
		mmio_write(ioapic_pkg::OFF_WINDOW, 32'h12345678);
		mmio_read(ioapic_pkg::OFF_WINDOW);
		mmio_write(ioapic_pkg::OFF_INDEX, 32'hff);
		mmio_read(ioapic_pkg::OFF_WINDOW);
		mmio_read(8'h20);
		mmio_write(8'hff, 32'hffffffff);
	endtask

	task automatic test_level_eoi();
		// pin 3: level, unmasked, vector 0x42; then EOI register and broadcast
		mmio_write(ioapic_pkg::OFF_INDEX, 32'h10 + 2 * 3 + 1);
		mmio_write(ioapic_pkg::OFF_WINDOW, 32'hab000000);
		mmio_write(ioapic_pkg::OFF_INDEX, 32'h10 + 2 * 3);
		mmio_write(ioapic_pkg::OFF_WINDOW, 32'h0000f942);
		pin_event(ioapic_pkg::FN_ASSERT, 3);
		mmio_read(ioapic_pkg::OFF_WINDOW);
		mmio_write(ioapic_pkg::OFF_EOI, 32'h142);
		mmio_write(ioapic_pkg::OFF_EOI, 32'h42);
		send_item(make_item(ioapic_pkg::FN_EOI, 0, 0, 0, 8'h42), 1'b1);
		pin_event(ioapic_pkg::FN_DEASRT, 3);
		pin_event(ioapic_pkg::FN_DEASRT, 3);
		pin_event(ioapic_pkg::FN_PULSE, 63);
		pin_event(ioapic_pkg::FN_PULSE, 5);
		send_item(make_item(3'd6, 0, 0, 0, 0), 1'b1);
		send_item(make_item(3'd7, 8'hff, 32'hffffffff, 6'h3f, 8'hff), 1'b1);
		wait_drained();
	endtask

	task automatic test_saturation();
		for (int i = 0; i < 129; i++)
			pin_event(ioapic_pkg::FN_DEASRT, 7);
		for (int i = 0; i < 129; i++)
			send_item(make_item(ioapic_pkg::FN_ASSERT, 0, 0, 8, 0), 1'b0);
	endtask

	// long receiver hold-off while transfers keep coming, then drain before more
	task automatic test_backpressure();
		hold_cycles = 200;
		for (int i = 0; i < 12; i++)
			send_item(make_item(ioapic_pkg::FN_PULSE, 0, 0, $urandom_range(0, PINS - 1), 0),
				1'b0);
		wait_drained();
		repeat (40) @(posedge clk);
	endtask

	task automatic test_random();
		int f;
		int p;
		for (int i = 0; i < N_RAND; i++) begin
			f = $urandom_range(0, 99);
			p = $urandom_range(0, PINS - 1);
			if (f < 20) begin
				mmio_write(ioapic_pkg::OFF_INDEX, 32'h10 + 2 * p + $urandom_range(0, 1));
				mmio_write(ioapic_pkg::OFF_WINDOW, {$urandom} & ($urandom_range(0, 1) ?
					32'hffff_fff0 | $urandom_range(0, 15) : 32'hffff_ffff));
			end else if (f < 28) begin
				mmio_write(ioapic_pkg::OFF_INDEX,
					$urandom_range(0, 1) ? $urandom : $urandom_range(0, 'h40));
				mmio_read($urandom_range(0, 1) ? ioapic_pkg::OFF_WINDOW
					: $urandom_range(0, 3) * 16);
			end else if (f < 55) begin
				pin_event($urandom_range(ioapic_pkg::FN_ASSERT, ioapic_pkg::FN_PULSE),
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : p);
			end else if (f < 68) begin
				mmio_write(ioapic_pkg::OFF_EOI,
					$urandom_range(0, 7) == 0 ? $urandom : sh_entry[p][7:0]);
			end else if (f < 82) begin
				send_item(make_item(ioapic_pkg::FN_EOI, $urandom, $urandom, $urandom,
					$urandom_range(0, 3) == 0 ? $urandom : sh_entry[p][7:0]), 1'b1);
			end else if (f < 92) begin
				// make a pin live: unmask with random vector and trigger mode
				mmio_write(ioapic_pkg::OFF_INDEX, 32'h10 + 2 * p);
				mmio_write(ioapic_pkg::OFF_WINDOW, {$urandom} & 32'hfffe_ffff);
			end else begin
				send_item(make_item($urandom_range(0, 7), $urandom, $urandom, $urandom,
					$urandom), 1'b1);
			end
		end
	endtask

	// receiver stall generator
	initial begin
		rsp_stall = 1'b1;
		hold_cycles = 0;
		rx_random = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else if (!rx_random) begin
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 49) == 0) begin
				rsp_stall <= 1'b1;
				hold_cycles = $urandom_range(6, 25);
			end else begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// result checker
	initial begin
		ioapic_pkg::out_t want;
		n_fail = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("unexpected result %h", rsp);
					n_fail++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp !== want) begin
						if (rsp.kind !== want.kind)
							$error("kind exp %h got %h", want.kind, rsp.kind);
						if (rsp.read_data !== want.read_data)
							$error("read_data exp %h got %h", want.read_data, rsp.read_data);
						if (rsp.int_vector !== want.int_vector)
							$error("int_vector exp %h got %h", want.int_vector, rsp.int_vector);
						if (rsp.destination !== want.destination)
							$error("destination exp %h got %h", want.destination, rsp.destination);
						if (rsp.dest_physical !== want.dest_physical)
							$error("dest_physical exp %h got %h", want.dest_physical,
								rsp.dest_physical);
						if (rsp.delivery_mode !== want.delivery_mode)
							$error("delivery_mode exp %h got %h", want.delivery_mode,
								rsp.delivery_mode);
						if (rsp.level_trigger !== want.level_trigger)
							$error("level_trigger exp %h got %h", want.level_trigger,
								rsp.level_trigger);
						if (rsp.error !== want.error)
							$error("error exp %h got %h", want.error, rsp.error);
						if (rsp.tmr_update !== want.tmr_update)
							$error("tmr_update exp %h got %h", want.tmr_update, rsp.tmr_update);
						if (rsp.remap_request !== want.remap_request)
							$error("remap_request exp %h got %h", want.remap_request,
								rsp.remap_request);
						if (rsp.last !== want.last)
							$error("last exp %h got %h", want.last, rsp.last);
						n_fail++;
					end
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int settle;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		sh_index = '0;
		sh_id = '0;
		for (int p = 0; p < PINS; p++) begin
			sh_entry[p] = ioapic_pkg::RESET_ENTRY;
			sh_count[p] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_id_version();
		test_level_eoi();
		test_backpressure();
		test_saturation();
		test_random();
		wait_drained();
		settle = 0;
		while (settle < 60) begin
			@(posedge clk);
			settle++;
		end
		if (n_fail == 0 && pending_rsp.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
